// ----- rtl/brf_pkg.sv -----
// brf_pkg: payload types, widths and codes of the bisection root finder
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package brf_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int TOL_WIDTH   = 31;
	localparam int DATA_WIDTH  = 32;
	localparam int ADDR_WIDTH  = 3;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_REPLY = 1'b1;

	localparam logic KIND_REQUEST = 1'b0;
	localparam logic KIND_DONE    = 1'b1;

	localparam logic [1:0] ST_BETWEEN = 2'd0;
	localparam logic [1:0] ST_LEFT    = 2'd1;
	localparam logic [1:0] ST_RIGHT   = 2'd2;
	localparam logic [1:0] ST_NONE    = 2'd3;

	localparam logic REG_TOLERANCE = 1'b0;

	typedef logic signed [VALUE_WIDTH-1:0] value_t;
	typedef logic [VALUE_WIDTH-1:0]        mag_t;
	typedef logic [TOL_WIDTH-1:0]          tol_t;

	typedef struct packed {
		logic   command;
		value_t left_end;
		value_t right_end;
		value_t func_value;
	} cmd_item_t;

	typedef struct packed {
		logic       kind;
		value_t     point;
		logic [1:0] status;
	} res_item_t;

	function automatic mag_t magnitude(input value_t x);
		mag_t m;
		m = mag_t'(x);
		return x[VALUE_WIDTH-1] ? (~m + mag_t'(1)) : m;
	endfunction

	// floor of the half sum, one bit wider so it cannot overflow
	function automatic value_t midpoint(input value_t a, input value_t b);
		logic signed [VALUE_WIDTH:0] s;
		s = {a[VALUE_WIDTH-1], a} + {b[VALUE_WIDTH-1], b};
		return value_t'(s[VALUE_WIDTH:1]);
	endfunction

	function automatic logic opposite(input value_t a, input value_t b);
		return (a != '0) && (b != '0) && (a[VALUE_WIDTH-1] != b[VALUE_WIDTH-1]);
	endfunction

endpackage

`default_nettype wire

// ----- rtl/bisection_root_finder_core.sv -----
// bisection_root_finder_core: top level with input and result registers
// depends on brf_pkg, brf_cfg, brf_engine
`timescale 1ns / 1ps
`default_nettype none

// Bisection root search controller for an outside function evaluator. A start
// transfer on cmd loads the interval ends; each result on res is either a
// request for f at a point (to be answered by a reply transfer) or the final
// report. The block takes one item per clock cycle with no bubbles while no
// result is held by res_stall. An item's transfer moves it into the input
// register; the search state is updated at the edge that moves its result
// into the result register, from which the result is offered on res. One item
// may wait in the input register while a result is held by res_stall. The
// tolerance register is written over APB at byte address 0 and should only be
// changed while no search item is open.
module bisection_root_finder_core (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cmd_valid,
	output logic                                cmd_stall,
	input  wire brf_pkg::cmd_item_t             cmd_item,
	output logic                                res_valid,
	input  wire logic                           res_stall,
	output brf_pkg::res_item_t                  res_item,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [brf_pkg::ADDR_WIDTH-1:0] paddr,
	input  wire logic [brf_pkg::DATA_WIDTH-1:0] pwdata,
	output logic      [brf_pkg::DATA_WIDTH-1:0] prdata,
	output logic                                pready
);
	import brf_pkg::*;

	logic      cmd_valid_s1;
	cmd_item_t cmd_item_s1;
	logic      res_valid_q;
	res_item_t res_item_q;
	logic      out_free, fire, has_result;
	res_item_t result;
	tol_t      tolerance;

	assign out_free  = !res_valid_q || !res_stall;
	assign fire      = cmd_valid_s1 && out_free;
	assign cmd_stall = cmd_valid_s1 && !out_free;
	assign res_valid = res_valid_q;
	assign res_item  = res_item_q;

	brf_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.tolerance (tolerance)
	);

	brf_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.item       (cmd_item_s1),
		.tolerance  (tolerance),
		.has_result (has_result),
		.result     (result)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_s1 <= 1'b0;
		end else if (!cmd_stall) begin
			cmd_valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!cmd_stall && cmd_valid) begin
			cmd_item_s1 <= cmd_item;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire && has_result) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && has_result) begin
			res_item_q <= result;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/brf_cfg.sv -----
// brf_cfg: apb register file holding the root tolerance
// depends on brf_pkg
`timescale 1ns / 1ps
`default_nettype none

module brf_cfg (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [brf_pkg::ADDR_WIDTH-1:0] paddr,
	input  wire logic [brf_pkg::DATA_WIDTH-1:0] pwdata,
	output logic      [brf_pkg::DATA_WIDTH-1:0] prdata,
	output logic                                pready,
	output brf_pkg::tol_t                       tolerance
);
	import brf_pkg::*;

	tol_t tolerance_q;
	logic reg_sel;

	assign reg_sel   = (paddr[ADDR_WIDTH-1] == REG_TOLERANCE);
	assign pready    = 1'b1;
	assign tolerance = tolerance_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tolerance_q <= tol_t'(1);
		end else if (psel && penable && pwrite && reg_sel) begin
			tolerance_q <= pwdata[TOL_WIDTH-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_sel) begin
			prdata = DATA_WIDTH'(tolerance_q);
		end
	end

endmodule

`default_nettype wire

// ----- rtl/brf_engine.sv -----
// brf_engine: search state registers and the per-item update logic
// depends on brf_pkg
`timescale 1ns / 1ps
`default_nettype none

module brf_engine (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               fire,
	input  wire brf_pkg::cmd_item_t item,
	input  wire brf_pkg::tol_t      tolerance,
	output logic                    has_result,
	output brf_pkg::res_item_t      result
);
	import brf_pkg::*;

	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_LEFT  = 2'd1;
	localparam logic [1:0] PH_RIGHT = 2'd2;
	localparam logic [1:0] PH_MID   = 2'd3;

	logic [1:0] phase_q, phase_d;
	value_t     left_pos_q, left_pos_d, right_pos_q, right_pos_d;
	value_t     left_val_q, left_val_d, right_val_q, right_val_d;
	value_t     mid_pos_q, mid_pos_d, prev_mid_q, prev_mid_d;
	logic       prev_mid_valid_q, prev_mid_valid_d;

	mag_t   tol_ext;
	logic   fv_root, lv_root;
	logic   keep_left;
	value_t new_left, new_right;

	assign tol_ext = mag_t'(tolerance);
	assign fv_root = magnitude(item.func_value) < tol_ext;
	assign lv_root = magnitude(left_val_q) < tol_ext;

	// narrow toward a sign change, else toward the smaller end value
	always_comb begin
		if (opposite(left_val_q, item.func_value)) begin
			keep_left = 1'b1;
		end else if (opposite(right_val_q, item.func_value)) begin
			keep_left = 1'b0;
		end else begin
			keep_left = magnitude(left_val_q) < magnitude(right_val_q);
		end
		new_left  = keep_left ? left_pos_q : mid_pos_q;
		new_right = keep_left ? mid_pos_q : right_pos_q;
	end

	always_comb begin
		phase_d          = phase_q;
		left_pos_d       = left_pos_q;
		right_pos_d      = right_pos_q;
		left_val_d       = left_val_q;
		right_val_d      = right_val_q;
		mid_pos_d        = mid_pos_q;
		prev_mid_d       = prev_mid_q;
		prev_mid_valid_d = prev_mid_valid_q;
		has_result       = 1'b0;
		result           = '{kind: KIND_REQUEST, point: '0, status: ST_BETWEEN};

		if (item.command == CMD_START) begin
			left_pos_d       = item.left_end;
			right_pos_d      = item.right_end;
			prev_mid_valid_d = 1'b0;
			phase_d          = PH_LEFT;
			has_result       = 1'b1;
			result.point     = item.left_end;
		end else begin
			case (phase_q)
				PH_IDLE: begin
					has_result = 1'b0;
				end
				PH_LEFT: begin
					left_val_d   = item.func_value;
					phase_d      = PH_RIGHT;
					has_result   = 1'b1;
					result.point = right_pos_q;
				end
				PH_RIGHT: begin
					right_val_d = item.func_value;
					has_result  = 1'b1;
					if (lv_root) begin
						phase_d = PH_IDLE;
						result  = '{kind: KIND_DONE, point: left_pos_q, status: ST_LEFT};
					end else if (fv_root) begin
						phase_d = PH_IDLE;
						result  = '{kind: KIND_DONE, point: right_pos_q, status: ST_RIGHT};
					end else begin
						mid_pos_d        = midpoint(left_pos_q, right_pos_q);
						prev_mid_valid_d = 1'b0;
						phase_d          = PH_MID;
						result.point     = mid_pos_d;
					end
				end
				PH_MID: begin
					has_result = 1'b1;
					if (fv_root) begin
						phase_d = PH_IDLE;
						result  = '{kind: KIND_DONE, point: mid_pos_q, status: ST_BETWEEN};
					end else if (prev_mid_valid_q && (mid_pos_q == prev_mid_q)) begin
						phase_d = PH_IDLE;
						result  = '{kind: KIND_DONE, point: mid_pos_q, status: ST_NONE};
					end else begin
						left_pos_d  = new_left;
						right_pos_d = new_right;
						if (keep_left) begin
							right_val_d = item.func_value;
						end else begin
							left_val_d = item.func_value;
						end
						prev_mid_d       = mid_pos_q;
						prev_mid_valid_d = 1'b1;
						mid_pos_d        = midpoint(new_left, new_right);
						result.point     = mid_pos_d;
					end
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q          <= PH_IDLE;
			left_pos_q       <= '0;
			right_pos_q      <= '0;
			left_val_q       <= '0;
			right_val_q      <= '0;
			mid_pos_q        <= '0;
			prev_mid_q       <= '0;
			prev_mid_valid_q <= 1'b0;
		end else if (fire) begin
			phase_q          <= phase_d;
			left_pos_q       <= left_pos_d;
			right_pos_q      <= right_pos_d;
			left_val_q       <= left_val_d;
			right_val_q      <= right_val_d;
			mid_pos_q        <= mid_pos_d;
			prev_mid_q       <= prev_mid_d;
			prev_mid_valid_q <= prev_mid_valid_d;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/brf_checker.sv -----
// brf_checker: port-level assertions for the bisection root finder
// depends on brf_pkg; bound to bisection_root_finder_core
`timescale 1ns / 1ps
`default_nettype none

module brf_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               cmd_stall,
	input wire logic               res_valid,
	input wire logic               res_stall,
	input wire brf_pkg::res_item_t res_item
);
	import brf_pkg::*;

	// a held result stays in place
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_item))
		else $error("result changed while stalled");

	// the input side only backs up behind a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> res_valid && res_stall)
		else $error("input stalled with the result side free");

	// requests carry no status
	a_req_status: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_item.kind == KIND_REQUEST) |-> res_item.status == ST_BETWEEN)
		else $error("request with nonzero status");

	// a stall lasts only while the result side stays blocked
	a_stall_release: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall && !res_stall |=> !cmd_stall)
		else $error("input stall held after result transfer");

endmodule

bind bisection_root_finder_core brf_checker u_brf_checker (.*);

`default_nettype wire
